// ===== hw/rtl/ssr_pkg.sv =====
// Shared types and constants for the servo slew position ramp.
// Depends on nothing; imported by the channel interfaces and every ramp module.
`default_nettype none

package ssr_pkg;

   // Fixed field widths
   localparam int KIND_W  = 2;
   localparam int RATE_W  = 8;
   localparam int TGT_W   = 16;
   localparam int PULSE_W = 11;
   localparam int MODE_W  = 2;
   localparam int POS_W   = 18;

   // Magnitude of a clamped position fits in 17 bits for every legal limit
   localparam int MAG_W      = POS_W - 1;
   // Reciprocal scaling shift: one bit beyond the magnitude keeps the
   // estimate within one of the true quotient
   localparam int RECIP_SH   = MAG_W + 1;
   // Quotient never exceeds the pulse span (at most 4095)
   localparam int SPAN_MAX_W = 12;

   // Item kinds
   localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_STOP   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RATE   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_TARGET = 2'd3;

   // Run modes
   localparam logic [MODE_W-1:0] MODE_IDLE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RATE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_POS  = 2'd2;

   // Tracker stage output: state after the item and whether to rescale
   typedef struct packed {
      logic                    recalc;
      logic [MODE_W-1:0]       mode;
      logic signed [POS_W-1:0] pos;
   } trk_type;

   // Scaler output: tracker info plus unsigned pulse magnitude
   typedef struct packed {
      trk_type                 trk;
      logic [SPAN_MAX_W-1:0]   quot;
   } scl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/ssr_if.sv =====
// Valid/ready channel interfaces for ramp commands and ramp results.
// Depends on ssr_pkg for the field widths.
`default_nettype none

interface ssr_req_if;
   import ssr_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [KIND_W-1:0]        kind;
   logic signed [RATE_W-1:0] rate;
   logic signed [TGT_W-1:0]  target;

   modport source (output valid, output kind, output rate, output target, input ready);
   modport sink   (input valid, input kind, input rate, input target, output ready);
endinterface

interface ssr_rsp_if;
   import ssr_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [PULSE_W-1:0] pulse;
   logic                      pulse_changed;
   logic [MODE_W-1:0]         mode_now;
   logic signed [POS_W-1:0]   position;

   modport source (output valid, output pulse, output pulse_changed, output mode_now,
                   output position, input ready);
   modport sink   (input valid, input pulse, input pulse_changed, input mode_now,
                   input position, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ssr_track.sv =====
// Ramp state tracker: applies commands and ticks to the position state.
// Depends on ssr_pkg and ssr_req_if; holds the first pipeline register.
`default_nettype none

module ssr_track
   import ssr_pkg::*;
#(
   parameter int STEP_MAX   = 127,
   parameter int RAMP_TICKS = 550
) (
   input  wire logic   clock,
   input  wire logic   reset,
   ssr_req_if.sink     req,
   input  wire logic   down_ready,
   output logic        trk_valid,
   output trk_type     trk
);

   localparam int PosLimit = STEP_MAX * RAMP_TICKS;
   localparam int EXT_W    = POS_W + 1;
   localparam logic signed [EXT_W-1:0] LimHi = EXT_W'(PosLimit);
   localparam logic signed [EXT_W-1:0] LimLo = -LimHi;
   localparam logic signed [EXT_W-1:0] StepX = EXT_W'(STEP_MAX);

   logic signed [POS_W-1:0]  pos_ff, pos_in;
   logic signed [TGT_W-1:0]  tgt_ff, tgt_in;
   logic signed [RATE_W-1:0] rate_ff, rate_in;
   logic [MODE_W-1:0]        mode_ff, mode_in;
   logic                     recalc;
   logic                     accept;
   logic                     valid_ff;
   trk_type                  trk_ff;

   assign req.ready = !valid_ff || down_ready;
   assign accept    = req.valid && req.ready;

   // Next state for one beat
   always_comb begin
      logic signed [EXT_W-1:0] pos_x;
      logic signed [EXT_W-1:0] tgt_x;
      logic signed [EXT_W-1:0] sum;
      logic signed [EXT_W-1:0] new_tgt;
      pos_x   = EXT_W'(pos_ff);
      tgt_x   = EXT_W'(tgt_ff);
      sum     = '0;
      new_tgt = EXT_W'(req.target);
      pos_in  = pos_ff;
      tgt_in  = tgt_ff;
      rate_in = rate_ff;
      mode_in = mode_ff;
      recalc  = 1'b0;
      unique case (req.kind)
         KIND_STOP: begin
            mode_in = MODE_IDLE;
         end
         KIND_RATE: begin
            rate_in = req.rate;
            mode_in = MODE_RATE;
         end
         KIND_TARGET: begin
            // clamp only bites when the limit is below the target range
            if (new_tgt > LimHi) begin
               new_tgt = LimHi;
            end else if (new_tgt < LimLo) begin
               new_tgt = LimLo;
            end
            tgt_in  = new_tgt[TGT_W-1:0];
            mode_in = MODE_POS;
         end
         default: begin
            // tick
            if (mode_ff == MODE_RATE) begin
               recalc = 1'b1;
               sum    = pos_x + EXT_W'(rate_ff);
               if (sum > LimHi) begin
                  sum = LimHi;
               end else if (sum < LimLo) begin
                  sum = LimLo;
               end
               pos_in = sum[POS_W-1:0];
            end else if (mode_ff == MODE_POS) begin
               recalc = 1'b1;
               if (tgt_x > pos_x) begin
                  sum = pos_x + StepX;
                  if (sum >= tgt_x) begin
                     sum     = tgt_x;
                     mode_in = MODE_IDLE;
                  end
               end else begin
                  sum = pos_x - StepX;
                  if (sum <= tgt_x) begin
                     sum     = tgt_x;
                     mode_in = MODE_IDLE;
                  end
               end
               pos_in = sum[POS_W-1:0];
            end
         end
      endcase
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         tgt_ff  <= '0;
         rate_ff <= '0;
         mode_ff <= MODE_IDLE;
      end else if (accept) begin
         pos_ff  <= pos_in;
         tgt_ff  <= tgt_in;
         rate_ff <= rate_in;
         mode_ff <= mode_in;
      end
   end

   // First pipeline register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req.ready) begin
         valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         trk_ff.recalc <= recalc;
         trk_ff.mode   <= mode_in;
         trk_ff.pos    <= pos_in;
      end
   end

   assign trk_valid = valid_ff;
   assign trk       = trk_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/ssr_scale.sv =====
// Pulse scaler: |position| * PULSE_SPAN / limit by reciprocal multiply,
// registered estimate, then one compare-and-add correction. Depends on ssr_pkg.
`default_nettype none

module ssr_scale
   import ssr_pkg::*;
#(
   parameter int PULSE_SPAN = 1000,
   parameter int STEP_MAX   = 127,
   parameter int RAMP_TICKS = 550
) (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   trk_valid,
   input  trk_type     trk,
   output logic        up_ready,
   input  wire logic   down_ready,
   output logic        scl_valid,
   output scl_type     scl
);

   localparam int     PosLimit = STEP_MAX * RAMP_TICKS;
   localparam int     SPAN_W   = $clog2(PULSE_SPAN + 1);
   localparam int     LIM_W    = $clog2(PosLimit + 1);
   localparam int     RECIP_W  = SPAN_W + RECIP_SH;
   localparam int     WIDE_W   = MAG_W + RECIP_W;
   localparam int     PROD_W   = MAG_W + SPAN_W;
   localparam int     BACK_W   = SPAN_MAX_W + LIM_W;
   localparam longint Recip    = (longint'(PULSE_SPAN) <<< RECIP_SH) / PosLimit;

   logic                  valid_ff;
   trk_type               trk_ff;
   logic [SPAN_MAX_W-1:0] qe_ff, qe_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [MAG_W-1:0]      mag;
   logic [WIDE_W-1:0]     wide;
   logic [BACK_W-1:0]     back;
   logic [PROD_W-1:0]     rem;

   assign up_ready = !valid_ff || down_ready;

   // Magnitude, exact product and quotient estimate
   always_comb begin
      logic signed [POS_W-1:0] abs_pos;
      abs_pos = trk.pos[POS_W-1] ? -trk.pos : trk.pos;
      mag     = abs_pos[MAG_W-1:0];
      wide    = WIDE_W'(mag) * WIDE_W'(Recip);
      qe_in   = SPAN_MAX_W'(wide >> RECIP_SH);
      prod_in = PROD_W'(mag) * PROD_W'(PULSE_SPAN);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= trk_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && trk_valid) begin
         trk_ff  <= trk;
         qe_ff   <= qe_in;
         prod_ff <= prod_in;
      end
   end

   // Estimate is the quotient or one short of it
   always_comb begin
      back     = BACK_W'(qe_ff) * BACK_W'(PosLimit);
      rem      = prod_ff - PROD_W'(back);
      scl.trk  = trk_ff;
      scl.quot = (rem >= PROD_W'(PosLimit)) ? qe_ff + 1'b1 : qe_ff;
   end

   assign scl_valid = valid_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/ssr_emit.sv =====
// Result stage: signs the pulse, tracks the last pulse and holds the result beat.
// Depends on ssr_pkg and ssr_rsp_if.
`default_nettype none

module ssr_emit
   import ssr_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   scl_valid,
   input  scl_type     scl,
   output logic        up_ready,
   ssr_rsp_if.source   rsp
);

   localparam int SQ_W = SPAN_MAX_W + 1;

   logic                      valid_ff;
   logic signed [PULSE_W-1:0] last_ff, last_in;
   logic signed [PULSE_W-1:0] pulse_ff;
   logic                      chg_ff, chg_in;
   logic [MODE_W-1:0]         mode_ff;
   logic signed [POS_W-1:0]   pos_ff;
   logic                      load;

   assign up_ready = !valid_ff || rsp.ready;
   assign load     = up_ready && scl_valid;

   // Signed pulse, wrapped to the field width, and change detect
   always_comb begin
      logic signed [SQ_W-1:0]    sq;
      logic signed [PULSE_W-1:0] pulse;
      sq      = {1'b0, scl.quot};
      if (scl.trk.pos[POS_W-1]) begin
         sq = -sq;
      end
      pulse   = sq[PULSE_W-1:0];
      last_in = last_ff;
      chg_in  = 1'b0;
      if (scl.trk.recalc && (pulse != last_ff)) begin
         last_in = pulse;
         chg_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         last_ff  <= '0;
      end else begin
         if (up_ready) begin
            valid_ff <= scl_valid;
         end
         if (load) begin
            last_ff <= last_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pulse_ff <= last_in;
         chg_ff   <= chg_in;
         mode_ff  <= scl.trk.mode;
         pos_ff   <= scl.trk.pos;
      end
   end

   assign rsp.valid         = valid_ff;
   assign rsp.pulse         = pulse_ff;
   assign rsp.pulse_changed = chg_ff;
   assign rsp.mode_now      = mode_ff;
   assign rsp.position      = pos_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/servo_slew_position_ramp_core.sv =====
// Servo slew position ramp, top level.
// Command/tick beats arrive on req_chan; each produces exactly one result beat
// on rsp_chan carrying pulse, pulse_changed, mode_now and position.
// Kinds: tick, stop, set rate (uses rate), set target (uses target).
// Rate mode adds the rate each tick, clamped to +/-STEP_MAX*RAMP_TICKS;
// position mode steps STEP_MAX toward the target, lands on it, then idles.
// Pulse is position*PULSE_SPAN/limit truncated toward zero.
// An accepted beat passes the state, estimate and result registers, in that
// order, to rsp_chan.valid. Throughput: one beat per cycle while
// rsp_chan.ready is high; the position state updates at the accepting edge,
// and the three-stage pipeline (state/estimate/result) is the only occupancy.
// Stalls: when rsp_chan.ready is low, stages fill behind the held result
// register and req_chan.ready drops once all three are full; no beat is
// dropped or repeated.
// Reset (synchronous, active high): position, target, rate and last pulse
// clear to zero, mode to idle, pipeline emptied. Depends on ssr_pkg, ssr_if.
`default_nettype none

module servo_slew_position_ramp_core
   import ssr_pkg::*;
#(
   parameter int PULSE_SPAN = 1000,
   parameter int STEP_MAX   = 127,
   parameter int RAMP_TICKS = 550
) (
   input  wire logic   clock,
   input  wire logic   reset,
   ssr_req_if.sink     req_chan,
   ssr_rsp_if.source   rsp_chan
);

   logic    trk_valid;
   trk_type trk;
   logic    scl_ready;
   logic    scl_valid;
   scl_type scl;
   logic    emit_ready;

   // Position state and first register
   ssr_track #(
      .STEP_MAX   (STEP_MAX),
      .RAMP_TICKS (RAMP_TICKS)
   ) u_track (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .down_ready (scl_ready),
      .trk_valid  (trk_valid),
      .trk        (trk)
   );

   // Constant-divisor pulse scaling
   ssr_scale #(
      .PULSE_SPAN (PULSE_SPAN),
      .STEP_MAX   (STEP_MAX),
      .RAMP_TICKS (RAMP_TICKS)
   ) u_scale (
      .clock      (clock),
      .reset      (reset),
      .trk_valid  (trk_valid),
      .trk        (trk),
      .up_ready   (scl_ready),
      .down_ready (emit_ready),
      .scl_valid  (scl_valid),
      .scl        (scl)
   );

   // Change detect and result register
   ssr_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .scl_valid (scl_valid),
      .scl       (scl),
      .up_ready  (emit_ready),
      .rsp       (rsp_chan)
   );

endmodule

`default_nettype wire

// ===== verif/servo_slew_position_ramp_core_tb.sv =====
// Self-checking testbench for servo_slew_position_ramp_core: directed, limit, random,
// back-pressure and streaming tests with an in-bench ramp predictor and scoreboard.
// Depends on ssr_pkg, ssr_if and the RTL of the ramp core.
`default_nettype none

module servo_slew_position_ramp_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ssr_pkg::*;

   localparam int SPAN        = 1000;
   localparam int STEP        = 127;
   localparam int POS_LIMIT   = 127 * 550;
   localparam int RANDOM_PART = 100;
   localparam int LAST_PART   = 60;

   typedef struct {
      logic signed [PULSE_W-1:0] pulse;
      logic                      changed;
      logic [MODE_W-1:0]         mode;
      logic signed [POS_W-1:0]   position;
   } ramp_result_type;

   logic clock;
   logic reset;

   ssr_req_if req_chan();
   ssr_rsp_if rsp_chan();

   servo_slew_position_ramp_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Ramp state as the predictor sees it
   int                pos_acc;
   int                tgt_pos;
   int                step_rate;
   logic [MODE_W-1:0] run_state;
   int                held_pulse;

   ramp_result_type expected_q[$];
   int              err_count;
   int              beats_sent;
   bit              req_idle_on;
   bit              rsp_idle_on;
   int              rsp_hold_cycles;
   int              rsp_stall_left;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic int clamp_limit(int v);
      if (v < -POS_LIMIT) return -POS_LIMIT;
      if (v > POS_LIMIT) return POS_LIMIT;
      return v;
   endfunction

   // Apply one accepted beat to the predicted state; return the result it yields
   function automatic ramp_result_type advance_ramp(logic [KIND_W-1:0] kind,
                                                    logic signed [RATE_W-1:0] rate,
                                                    logic signed [TGT_W-1:0] tgt);
      ramp_result_type r;
      int              p;
      r.changed = 1'b0;
      case (kind)
         KIND_STOP: run_state = MODE_IDLE;
         KIND_RATE: begin
            step_rate = int'(rate);
            run_state = MODE_RATE;
         end
         KIND_TARGET: begin
            tgt_pos   = clamp_limit(int'(tgt));
            run_state = MODE_POS;
         end
         default: begin
            // tick: only rate and position modes move
            if (run_state == MODE_RATE || run_state == MODE_POS) begin
               if (run_state == MODE_RATE) begin
                  pos_acc = clamp_limit(pos_acc + step_rate);
               end else if (tgt_pos > pos_acc) begin
                  pos_acc += STEP;
                  if (pos_acc >= tgt_pos) begin
                     pos_acc   = tgt_pos;
                     run_state = MODE_IDLE;
                  end
               end else begin
                  pos_acc -= STEP;
                  if (pos_acc <= tgt_pos) begin
                     pos_acc   = tgt_pos;
                     run_state = MODE_IDLE;
                  end
               end
               // division truncates toward zero
               p = int'((longint'(pos_acc) * SPAN) / POS_LIMIT);
               if (p != held_pulse) begin
                  held_pulse = p;
                  r.changed  = 1'b1;
               end
            end
         end
      endcase
      r.pulse    = held_pulse[PULSE_W-1:0];
      r.mode     = run_state;
      r.position = pos_acc[POS_W-1:0];
      return r;
   endfunction

   task automatic note_failure(string msg);
      err_count++;
      if (err_count <= 10) $display("ERROR @%0t: %s", $time, msg);
   endtask

   // Send one beat; called and returns at a falling edge, valid left high
   task automatic send_beat(logic [KIND_W-1:0] kind, logic signed [RATE_W-1:0] rate,
                            logic signed [TGT_W-1:0] tgt);
      int gap;
      if (req_idle_on && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 18);
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.kind   <= kind;
      req_chan.rate   <= rate;
      req_chan.target <= tgt;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      expected_q.push_back(advance_ramp(kind, rate, tgt));
      beats_sent++;
      @(negedge clock);
   endtask

   // Ticks carry random values in the unused fields
   task automatic send_ticks(int n);
      repeat (n) send_beat(KIND_TICK, RATE_W'($urandom), TGT_W'($urandom));
   endtask

   task automatic drain;
      req_chan.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (8) @(negedge clock);
   endtask

   // Receiver: long hold-off first, then random stall bursts
   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_chan.ready <= 1'b0;
         rsp_hold_cycles--;
      end else if (rsp_stall_left > 0) begin
         rsp_chan.ready <= 1'b0;
         rsp_stall_left--;
      end else if (rsp_idle_on && $urandom_range(0, 7) == 0) begin
         rsp_stall_left = $urandom_range(1, 18) - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // Scoreboard: each result beat against the oldest prediction
   always @(posedge clock) begin
      ramp_result_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (expected_q.size() == 0) begin
            note_failure("result beat with no prediction pending");
         end else begin
            want = expected_q.pop_front();
            if (rsp_chan.pulse !== want.pulse || rsp_chan.pulse_changed !== want.changed ||
                rsp_chan.mode_now !== want.mode || rsp_chan.position !== want.position)
               note_failure($sformatf(
                  "exp pulse=%0d chg=%0d mode=%0d pos=%0d, got pulse=%0d chg=%0d mode=%0d pos=%0d",
                  want.pulse, want.changed, want.mode, want.position, rsp_chan.pulse,
                  rsp_chan.pulse_changed, rsp_chan.mode_now, rsp_chan.position));
         end
      end
   end

   // Idle tick, target equal to position, exact landing, all kinds, field extremes
   task automatic test_directed;
      send_ticks(1);
      send_beat(KIND_TARGET, 8'sd0, 16'sd0);
      send_ticks(1);
      send_beat(KIND_TARGET, -8'sd1, 16'sh7fff);
      send_ticks(3);
      send_beat(KIND_STOP, 8'sh7f, 16'sh7fff);
      send_ticks(1);
      send_beat(KIND_TARGET, 8'sd0, 16'sd400);
      send_ticks(2);
      send_beat(KIND_TARGET, 8'sh7f, 16'sh8000);
      send_ticks(2);
      send_beat(KIND_RATE, 8'sd127, 16'sd0);
      send_ticks(1);
      send_beat(KIND_RATE, 8'sh80, -16'sd1);
      send_ticks(2);
      send_beat(KIND_RATE, 8'sd0, 16'sd0);
      send_ticks(1);
      send_beat(KIND_TARGET, 8'sd5, 16'sd1);
      send_beat(KIND_STOP, 8'sh80, 16'sh8000);
      send_ticks(1);
      drain();
   endtask

   // Drive the position into the top clamp, sit on it, then back off
   task automatic test_clamp_limits;
      send_beat(KIND_RATE, 8'sd127, TGT_W'($urandom));
      while (pos_acc != POS_LIMIT) send_ticks(1);
      send_ticks(3);
      send_beat(KIND_RATE, 8'sh80, TGT_W'($urandom));
      send_ticks(2);
      send_beat(KIND_STOP, RATE_W'($urandom), TGT_W'($urandom));
      send_ticks(1);
      drain();
   endtask

   // Mostly command-then-ticks sequences with random content, some noise
   task automatic test_random_sequences(int n_beats, bit idle_mix);
      int                       start;
      int                       t;
      int                       cap;
      logic signed [RATE_W-1:0] r;
      start = beats_sent;
      while (beats_sent - start < n_beats) begin
         if (idle_mix) begin
            req_idle_on = ($urandom_range(0, 3) != 0);
            rsp_idle_on = ($urandom_range(0, 3) != 0);
         end
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               case ($urandom_range(0, 5))
                  0: t = pos_acc;
                  1: t = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
                  2: t = int'($signed(TGT_W'($urandom)));
                  default: t = pos_acc + int'($urandom_range(0, 6000)) - 3000;
               endcase
               if (t > 32767) t = 32767;
               if (t < -32768) t = -32768;
               send_beat(KIND_TARGET, RATE_W'($urandom), TGT_W'(t));
               cap = $urandom_range(1, 100);
               while (run_state == MODE_POS && cap > 0) begin
                  send_ticks(1);
                  cap--;
               end
            end
            4, 5, 6: begin
               case ($urandom_range(0, 4))
                  0: r = 8'sd127;
                  1: r = 8'sh80;
                  2: r = 8'sd0;
                  default: r = RATE_W'($urandom);
               endcase
               send_beat(KIND_RATE, r, TGT_W'($urandom));
               send_ticks($urandom_range(1, 40));
            end
            7: begin
               send_beat(KIND_STOP, RATE_W'($urandom), TGT_W'($urandom));
               send_ticks($urandom_range(0, 3));
            end
            8: send_beat(KIND_W'($urandom), RATE_W'($urandom), TGT_W'($urandom));
            default: send_ticks($urandom_range(1, 10));
         endcase
      end
      drain();
   endtask

   // Receiver holds off while the sender keeps offering beats
   task automatic test_backpressure;
      req_idle_on     = 1'b0;
      rsp_hold_cycles = 150;
      send_beat(KIND_RATE, 8'sd90, TGT_W'($urandom));
      send_ticks(20);
      send_beat(KIND_TARGET, RATE_W'($urandom), -16'sd2000);
      send_ticks(20);
      drain();
   endtask

   // Final stretch with neither side idling
   task automatic test_streaming;
      req_idle_on    = 1'b0;
      rsp_idle_on    = 1'b0;
      rsp_stall_left = 0;
      test_random_sequences(LAST_PART, 1'b0);
   endtask

   initial begin
      reset           = 1'b1;
      req_chan.valid  = 1'b0;
      req_chan.kind   = KIND_TICK;
      req_chan.rate   = '0;
      req_chan.target = '0;
      rsp_chan.ready  = 1'b0;
      pos_acc         = 0;
      tgt_pos         = 0;
      step_rate       = 0;
      run_state       = MODE_IDLE;
      held_pulse      = 0;
      err_count       = 0;
      beats_sent      = 0;
      req_idle_on     = 1'b1;
      rsp_idle_on     = 1'b1;
      rsp_hold_cycles = 0;
      rsp_stall_left  = 0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_clamp_limits();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      test_random_sequences(RANDOM_PART, 1'b1);
      test_backpressure();
      test_streaming();

      if (err_count == 0 && expected_q.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/ssr_pkg.sv
hw/rtl/ssr_if.sv
hw/rtl/ssr_track.sv
hw/rtl/ssr_scale.sv
hw/rtl/ssr_emit.sv
hw/rtl/servo_slew_position_ramp_core.sv
verif/servo_slew_position_ramp_core_tb.sv
